// ----- rtl/sfmp_pkg.sv -----
package sfmp_pkg;

	typedef enum logic [2:0] {
		PH_SYNC1,
		PH_SYNC2,
		PH_TYPE,
		PH_PAYLOAD,
		PH_CHECK,
		PH_EMIT
	} phase_t;

	localparam logic [2:0] K_UPDATE = 3'd0;
	localparam logic [2:0] K_COUNT  = 3'd1;
	localparam logic [2:0] K_HEART  = 3'd2;
	localparam logic [2:0] K_USAGE  = 3'd3;
	localparam logic [2:0] K_SHOT   = 3'd4;
	localparam logic [2:0] K_STATUS = 3'd5;
	localparam logic [2:0] K_TEXT   = 3'd6;

	localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
	localparam logic [2:0] REG_SYNC_SECOND = 3'd1;

	// controller to datapath
	typedef struct packed {
		logic start;      // type byte accepted: init xor, count, kind
		logic store;      // payload byte accepted
		logic load_hdr;   // build header result into output register
		logic load_text;  // build next text result (store read issued earlier)
		logic rd_next;    // advance text read pointer
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       type_hit;
		logic       full;
		logic       frame_done;
		logic       xor_ok;
		logic       decode_ok;
		logic [5:0] text_left;
	} dp_stat_t;

endpackage

// ----- rtl/sfmp_ctrl.sv -----
module sfmp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                b_sync1,
	input  logic                b_sync2,
	input  sfmp_pkg::dp_stat_t  stat,
	input  logic                out_busy,
	input  logic                out_fire,
	output sfmp_pkg::dp_cmd_t   cmd,
	output logic                in_ready
);

	sfmp_pkg::phase_t state_q, state_d;
	logic             hdr_q; // header of the run not yet loaded

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfmp_pkg::PH_SYNC1;
			hdr_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_hdr)
				hdr_q <= 1'b0;
			else if (state_q == sfmp_pkg::PH_CHECK && in_fire)
				hdr_q <= 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sfmp_pkg::PH_SYNC1:
				if (in_fire && b_sync1) state_d = sfmp_pkg::PH_SYNC2;
			sfmp_pkg::PH_SYNC2:
				if (in_fire) state_d = b_sync2 ? sfmp_pkg::PH_TYPE : sfmp_pkg::PH_SYNC1;
			sfmp_pkg::PH_TYPE:
				if (in_fire) begin
					if (!stat.type_hit) state_d = sfmp_pkg::PH_SYNC1;
					else if (stat.frame_done) state_d = sfmp_pkg::PH_CHECK;
					else state_d = sfmp_pkg::PH_PAYLOAD;
				end
			sfmp_pkg::PH_PAYLOAD:
				if (in_fire) begin
					if (stat.full) state_d = sfmp_pkg::PH_SYNC1;
					else if (stat.frame_done) state_d = sfmp_pkg::PH_CHECK;
				end
			sfmp_pkg::PH_CHECK:
				if (in_fire)
					state_d = (stat.xor_ok && stat.decode_ok) ? sfmp_pkg::PH_EMIT
						: sfmp_pkg::PH_SYNC1;
			sfmp_pkg::PH_EMIT:
				if (!hdr_q && stat.text_left == 6'd0 && !out_busy)
					state_d = sfmp_pkg::PH_SYNC1;
			default: state_d = sfmp_pkg::PH_SYNC1;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			sfmp_pkg::PH_EMIT: begin
				if (!out_busy || out_fire) begin
					if (hdr_q) begin
						cmd.load_hdr = 1'b1;
						cmd.rd_next  = 1'b1;
					end else if (stat.text_left != 6'd0) begin
						cmd.load_text = 1'b1;
						cmd.rd_next   = 1'b1;
					end
				end
			end
			sfmp_pkg::PH_TYPE: begin
				in_ready  = 1'b1;
				cmd.start = in_fire;
			end
			sfmp_pkg::PH_PAYLOAD: begin
				in_ready  = 1'b1;
				cmd.store = in_fire && !stat.full;
			end
			default: in_ready = 1'b1;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_hdr |-> !cmd.load_text)
		else $error("header and text loaded together");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sfmp_pkg::PH_EMIT) |-> !in_ready)
		else $error("input taken while emitting");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !stat.full)
		else $error("store write beyond depth");

endmodule

// ----- rtl/sfmp_dp.sv -----
module sfmp_dp #(
	parameter int BUF_DEPTH      = 64,
	parameter int MAX_NAME_LEN   = 32,
	parameter int MAX_TEXT_LEN   = 32,
	parameter int MAX_STATE_CODE = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          code [6],
	input  sfmp_pkg::dp_cmd_t   cmd,
	input  logic                out_fire,
	output sfmp_pkg::dp_stat_t  stat,
	output logic                out_valid,
	output logic [2:0]          kind,
	output logic                last,
	output logic [7:0]          agent_num,
	output logic [7:0]          char_state,
	output logic [7:0]          agent_count,
	output logic [31:0]         timestamp,
	output logic [7:0]          current_pct,
	output logic [7:0]          weekly_pct,
	output logic [15:0]         current_reset_min,
	output logic [15:0]         weekly_reset_min,
	output logic [5:0]          text_count,
	output logic [7:0]          text_byte
);

	localparam int AW = $clog2(BUF_DEPTH);
	localparam int CW = AW + 1;

	logic [7:0]    mem [BUF_DEPTH];
	logic [7:0]    rd_data_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] rd_first;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] count_q;
	logic [6:0]    exp_len_q;
	logic          len_known_q;
	logic [7:0]    xor_q;
	logic [2:0]    kind_q;
	// header bytes captured as they arrive
	logic [7:0]    h_q [6];
	logic [5:0]    left_q;
	logic [5:0]    tlen_q;

	// type decode, first match wins
	logic [2:0] hit_k;
	logic       hit;
	always_comb begin
		hit   = 1'b0;
		hit_k = sfmp_pkg::K_UPDATE;
		for (int k = 5; k >= 0; k--)
			if (code[k] == rx_byte) begin
				hit   = 1'b1;
				hit_k = 3'(k);
			end
	end

	logic [6:0] fixed_len;
	always_comb begin
		case (hit_k)
			sfmp_pkg::K_COUNT: fixed_len = 7'd1;
			sfmp_pkg::K_HEART: fixed_len = 7'd4;
			sfmp_pkg::K_USAGE: fixed_len = 7'd6;
			default:           fixed_len = 7'd0;
		endcase
	end

	logic [CW-1:0] cnt_n;
	logic [7:0]    nlen, tclamp;
	logic [6:0]    exp_n;
	logic          known_n;
	assign cnt_n  = count_q + 1'b1;
	assign nlen   = (rx_byte > 8'(MAX_NAME_LEN)) ? 8'(MAX_NAME_LEN) : rx_byte;
	assign tclamp = (rx_byte > 8'(MAX_TEXT_LEN)) ? 8'(MAX_TEXT_LEN) : rx_byte;
	always_comb begin
		exp_n   = exp_len_q;
		known_n = len_known_q;
		if (!len_known_q) begin
			if (kind_q == sfmp_pkg::K_UPDATE && cnt_n == CW'(3)) begin
				exp_n   = 7'(nlen) + 7'd3;
				known_n = 1'b1;
			end else if (kind_q == sfmp_pkg::K_STATUS && cnt_n == CW'(2)) begin
				exp_n   = 7'(tclamp) + 7'd2;
				known_n = 1'b1;
			end
		end
	end

	logic decode_ok;

	assign stat.type_hit   = hit;
	assign stat.full       = count_q >= CW'(BUF_DEPTH);
	assign stat.frame_done = cmd.start ? (fixed_len == 7'd0 && hit_k != sfmp_pkg::K_UPDATE
		&& hit_k != sfmp_pkg::K_STATUS)
		: (known_n && 8'(cnt_n) >= 8'(exp_n));
	assign stat.xor_ok     = xor_q == rx_byte;
	assign stat.decode_ok  = decode_ok;
	assign stat.text_left  = left_q;

	// length actually emitted, bounded by bytes received
	logic [7:0] have_upd, have_st, len_upd, len_st;
	assign have_upd = 8'(count_q) - 8'd3;
	assign have_st  = 8'(count_q) - 8'd2;
	assign len_upd  = ((h_q[2] > 8'(MAX_NAME_LEN)) ? 8'(MAX_NAME_LEN) : h_q[2]);
	assign len_st   = ((h_q[1] > 8'(MAX_TEXT_LEN)) ? 8'(MAX_TEXT_LEN) : h_q[1]);

	logic [5:0] eff_len;
	always_comb begin
		decode_ok = 1'b0;
		eff_len   = 6'd0;
		case (kind_q)
			sfmp_pkg::K_UPDATE: begin
				decode_ok = count_q >= CW'(3) && h_q[1] <= 8'(MAX_STATE_CODE);
				eff_len = 6'((len_upd > have_upd) ? have_upd : len_upd);
			end
			sfmp_pkg::K_COUNT:  decode_ok = count_q >= CW'(1);
			sfmp_pkg::K_HEART:  decode_ok = count_q >= CW'(4);
			sfmp_pkg::K_USAGE:  decode_ok = count_q >= CW'(6);
			sfmp_pkg::K_SHOT:   decode_ok = 1'b1;
			sfmp_pkg::K_STATUS: begin
				decode_ok = count_q >= CW'(2);
				eff_len = 6'((len_st > have_st) ? have_st : len_st);
			end
			default: decode_ok = 1'b0;
		endcase
	end

	// read address runs ahead of the pointer so rd_data_q holds the next text byte
	assign rd_first = AW'((kind_q == sfmp_pkg::K_UPDATE) ? 3 : 2);
	always_comb begin
		if (cmd.load_hdr)
			rd_addr = rd_first;
		else if (cmd.rd_next)
			rd_addr = rd_ptr_q + 1'b1;
		else
			rd_addr = rd_ptr_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.store)
			mem[count_q[AW-1:0]] <= rx_byte;
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.store)
			for (int i = 0; i < 6; i++)
				if (count_q == CW'(i)) h_q[i] <= rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			exp_len_q   <= '0;
			len_known_q <= 1'b0;
			xor_q       <= '0;
			kind_q      <= sfmp_pkg::K_UPDATE;
			rd_ptr_q    <= '0;
			left_q      <= '0;
			tlen_q      <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (cmd.start) begin
				kind_q      <= hit_k;
				xor_q       <= rx_byte;
				count_q     <= '0;
				len_known_q <= !(hit_k == sfmp_pkg::K_UPDATE || hit_k == sfmp_pkg::K_STATUS);
				exp_len_q   <= fixed_len;
			end
			if (cmd.store) begin
				count_q     <= cnt_n;
				xor_q       <= xor_q ^ rx_byte;
				exp_len_q   <= exp_n;
				len_known_q <= known_n;
			end
			if (cmd.load_hdr) begin
				rd_ptr_q <= rd_first;
				left_q   <= eff_len;
				tlen_q   <= eff_len;
			end else if (cmd.rd_next) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
				left_q   <= left_q - 1'b1;
			end
			if (cmd.load_hdr || cmd.load_text)
				out_valid <= 1'b1;
			else if (out_fire)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_hdr) begin
			kind              <= kind_q;
			last              <= eff_len == 6'd0;
			agent_num         <= (kind_q == sfmp_pkg::K_UPDATE || kind_q == sfmp_pkg::K_STATUS)
				? h_q[0] : 8'd0;
			char_state        <= (kind_q == sfmp_pkg::K_UPDATE) ? h_q[1] : 8'd0;
			agent_count       <= (kind_q == sfmp_pkg::K_COUNT) ? h_q[0] : 8'd0;
			timestamp         <= (kind_q == sfmp_pkg::K_HEART)
				? {h_q[0], h_q[1], h_q[2], h_q[3]} : 32'd0;
			current_pct       <= (kind_q == sfmp_pkg::K_USAGE) ? h_q[0] : 8'd0;
			weekly_pct        <= (kind_q == sfmp_pkg::K_USAGE) ? h_q[1] : 8'd0;
			current_reset_min <= (kind_q == sfmp_pkg::K_USAGE) ? {h_q[2], h_q[3]} : 16'd0;
			weekly_reset_min  <= (kind_q == sfmp_pkg::K_USAGE) ? {h_q[4], h_q[5]} : 16'd0;
			text_count        <= (kind_q == sfmp_pkg::K_UPDATE || kind_q == sfmp_pkg::K_STATUS)
				? eff_len : 6'd0;
			text_byte         <= 8'd0;
		end else if (cmd.load_text) begin
			kind              <= sfmp_pkg::K_TEXT;
			last              <= left_q == 6'd1;
			agent_num         <= 8'd0;
			char_state        <= 8'd0;
			agent_count       <= 8'd0;
			timestamp         <= 32'd0;
			current_pct       <= 8'd0;
			weekly_pct        <= 8'd0;
			current_reset_min <= 16'd0;
			weekly_reset_min  <= 16'd0;
			text_count        <= 6'd0;
			text_byte         <= rd_data_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_text |-> left_q != 6'd0)
		else $error("text result with none left");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_hdr |=> left_q <= tlen_q)
		else $error("text count past header length");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_fire) |=> out_valid)
		else $error("result dropped");

endmodule

// ----- rtl/sync_framed_message_parser.sv -----
// channel | dir | tdata (low bit first)               | tuser | tlast
// s_axis  | in  | rx_byte[7:0]                        | -     | -
// m_axis  | out | agent_num, char_state, agent_count,  | kind  | last
//         |     | timestamp, current_pct, weekly_pct, |       |
//         |     | current_reset_min, weekly_reset_min,|       |
//         |     | text_count(6), text_byte, 2 pad bits|       |
// one byte is taken per cycle while hunting or reading a frame.
// after a good checksum byte the header is loaded the next cycle, then each text
// byte follows one per cycle through the output register while m_axis_tready is high.
// no input is taken while emitting or before the output register has emptied.
// reset clears control state; the payload store is not cleared.
module sync_framed_message_parser #(
	parameter int BUF_DEPTH      = 64,
	parameter int MAX_NAME_LEN   = 32,
	parameter int MAX_TEXT_LEN   = 32,
	parameter int MAX_STATE_CODE = 7
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // rx_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [119:0] m_axis_tdata,  // agent_num..text_byte as listed above
	output logic [2:0]   m_axis_tuser,  // kind
	output logic         m_axis_tlast,  // last
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [7:0]   cfg_data
);

	logic [7:0] sync1_q, sync2_q;
	logic [7:0] code_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync1_q <= 8'd170;
			sync2_q <= 8'd85;
			for (int i = 0; i < 6; i++) code_q[i] <= 8'(i + 1);
		end else if (cfg_we) begin
			if (cfg_index == sfmp_pkg::REG_SYNC_FIRST) sync1_q <= cfg_data;
			else if (cfg_index == sfmp_pkg::REG_SYNC_SECOND) sync2_q <= cfg_data;
			else code_q[cfg_index - 3'd2] <= cfg_data;
		end
	end

	sfmp_pkg::dp_cmd_t  cmd;
	sfmp_pkg::dp_stat_t stat;
	logic in_fire, out_fire;
	logic [7:0] agent_num, char_state, agent_count, current_pct, weekly_pct, text_byte;
	logic [31:0] timestamp;
	logic [15:0] current_reset_min, weekly_reset_min;
	logic [5:0]  text_count;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	sfmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.b_sync1  (s_axis_tdata == sync1_q),
		.b_sync2  (s_axis_tdata == sync2_q),
		.stat     (stat),
		.out_busy (m_axis_tvalid),
		.out_fire (out_fire),
		.cmd      (cmd),
		.in_ready (s_axis_tready)
	);

	sfmp_dp #(
		.BUF_DEPTH      (BUF_DEPTH),
		.MAX_NAME_LEN   (MAX_NAME_LEN),
		.MAX_TEXT_LEN   (MAX_TEXT_LEN),
		.MAX_STATE_CODE (MAX_STATE_CODE)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.rx_byte           (s_axis_tdata),
		.code              (code_q),
		.cmd               (cmd),
		.out_fire          (out_fire),
		.stat              (stat),
		.out_valid         (m_axis_tvalid),
		.kind              (m_axis_tuser),
		.last              (m_axis_tlast),
		.agent_num         (agent_num),
		.char_state        (char_state),
		.agent_count       (agent_count),
		.timestamp         (timestamp),
		.current_pct       (current_pct),
		.weekly_pct        (weekly_pct),
		.current_reset_min (current_reset_min),
		.weekly_reset_min  (weekly_reset_min),
		.text_count        (text_count),
		.text_byte         (text_byte)
	);

	assign m_axis_tdata = {2'b00, text_byte, text_count, weekly_reset_min, current_reset_min,
		weekly_pct, current_pct, timestamp, agent_count, char_state, agent_num};

endmodule
